/* hdl/spq_pkg.sv */
// Shared types, constants and helpers for the stable priority queue.
// Used by spq_ctrl, spq_dp and stable_priority_queue; depends on nothing.
package spq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int TAG_W  = 64;
    localparam int CODE_W = 3;
    localparam int ENT_W  = TAG_W + CODE_W;

    // request payload: name_tag, state_code (mode travels in tuser)
    localparam int IN_W   = 72;
    // result payload: status, found, removed_tag, removed_state, entry_count
    localparam int OUT_W  = 80;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_INS_FIRST,
        OP_INS_SHIFT,
        OP_INS_PLACE,
        OP_HEAD_READ,
        OP_REM_POP,
        OP_SRCH_NEXT,
        OP_SRCH_HIT,
        OP_SET_FULL,
        OP_SET_EMPTY,
        OP_COMMIT
    } dp_op_t;

    typedef struct packed {
        mode_t mode;
        logic  cnt_zero;
        logic  full;
        logic  ins_stop;
        logic  idx_one;
        logic  hit;
        logic  srch_last;
        logic  out_free;
    } dp_status_t;

    function automatic logic [1:0] prio_of(input logic [CODE_W-1:0] code);
        logic [1:0] p;
        case (code)
            3'd1:    p = 2'd3;
            3'd2:    p = 2'd2;
            3'd3:    p = 2'd1;
            default: p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

/* hdl/spq_dp.sv */
// Datapath of the stable priority queue: entry memory (circular, head pointer),
// walk index, request capture and result register. Depends on spq_pkg.
module spq_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  spq_pkg::dp_op_t           op,
    input  logic [1:0]                req_mode,
    input  logic [spq_pkg::IN_W-1:0]  req_data,
    output spq_pkg::dp_status_t       stat,
    output logic                      res_valid,
    input  logic                      res_ready,
    output logic [spq_pkg::OUT_W-1:0] res_data
);
    import spq_pkg::*;

    logic [ENT_W-1:0]  mem [DEPTH];
    logic [ENT_W-1:0]  rd_data_reg;

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              res_valid_reg, res_valid_next;

    mode_t             mode_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [CODE_W-1:0] code_reg;
    status_t           rstat_reg;
    logic              found_reg;
    logic [TAG_W-1:0]  rtag_reg;
    logic [CODE_W-1:0] rcode_reg;
    logic [OUT_W-1:0]  out_reg;

    logic              rd_en, wr_en;
    logic [IDX_W-1:0]  rd_log, wr_log;
    logic [ENT_W-1:0]  wr_data;
    logic [CNT_W-1:0]  idx_ext;
    logic [CNT_W+4:0]  cnt_wide;

    // logical position from head to physical slot
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                              input logic [IDX_W-1:0] k);
        logic [IDX_W:0] s;
        s = {1'b0, h} + {1'b0, k};
        if (s >= (IDX_W+1)'(DEPTH))
            s = s - (IDX_W+1)'(DEPTH);
        return s[IDX_W-1:0];
    endfunction

    assign idx_ext  = CNT_W'(idx_reg);
    assign cnt_wide = {5'd0, cnt_reg};

    always_comb
    begin
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        rd_log    = idx_reg;
        wr_log    = idx_reg;
        wr_data   = {code_reg, tag_reg};
        head_next = head_reg;
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        case (op)
            OP_CAPTURE:
            begin
                idx_next = '0;
            end
            OP_INS_FIRST:
            begin
                rd_en    = 1'b1;
                rd_log   = IDX_W'(cnt_reg - 1'b1);
                idx_next = IDX_W'(cnt_reg);
            end
            OP_INS_SHIFT:
            begin
                // move the lower-priority entry one place towards the tail
                wr_en    = 1'b1;
                wr_data  = rd_data_reg;
                rd_en    = (idx_reg != IDX_W'(1));
                rd_log   = idx_reg - IDX_W'(2);
                idx_next = idx_reg - 1'b1;
            end
            OP_INS_PLACE:
            begin
                wr_en    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            OP_HEAD_READ:
            begin
                rd_en    = 1'b1;
                rd_log   = '0;
                idx_next = '0;
            end
            OP_REM_POP:
            begin
                head_next = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
                cnt_next  = cnt_reg - 1'b1;
            end
            OP_SRCH_NEXT:
            begin
                rd_en    = 1'b1;
                rd_log   = idx_reg + 1'b1;
                idx_next = idx_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_ready)
            res_valid_next = 1'b0;
        if (op == OP_COMMIT)
            res_valid_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[phys(head_reg, wr_log)] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[phys(head_reg, rd_log)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_CAPTURE:
            begin
                mode_reg  <= mode_t'(req_mode);
                tag_reg   <= req_data[TAG_W-1:0];
                code_reg  <= req_data[TAG_W +: CODE_W];
                rstat_reg <= ST_OK;
                found_reg <= 1'b0;
                rtag_reg  <= '0;
                rcode_reg <= '0;
            end
            OP_REM_POP:
            begin
                rtag_reg  <= rd_data_reg[TAG_W-1:0];
                rcode_reg <= rd_data_reg[TAG_W +: CODE_W];
            end
            OP_SRCH_HIT:  found_reg <= 1'b1;
            OP_SET_FULL:  rstat_reg <= ST_FULL;
            OP_SET_EMPTY: rstat_reg <= ST_EMPTY;
            OP_COMMIT:
                out_reg <= {5'd0, cnt_wide[4:0], rcode_reg, rtag_reg, found_reg, rstat_reg};
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat.mode      = mode_reg;
        stat.cnt_zero  = (cnt_reg == '0);
        stat.full      = (cnt_reg == CNT_W'(DEPTH));
        stat.ins_stop  = (prio_of(rd_data_reg[TAG_W +: CODE_W]) >= prio_of(code_reg));
        stat.idx_one   = (idx_reg == IDX_W'(1));
        stat.hit       = (rd_data_reg[TAG_W-1:0] == tag_reg);
        stat.srch_last = (idx_ext + 1'b1 == cnt_reg);
        stat.out_free  = !res_valid_reg || res_ready;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = out_reg;

endmodule

/* hdl/spq_ctrl.sv */
// Controller of the stable priority queue: sequences one request at a time
// by issuing datapath operations. Depends on spq_pkg.
module spq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  spq_pkg::dp_status_t stat,
    output spq_pkg::dp_op_t     op
);
    import spq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_PLACE,
        S_REM,
        S_SRCH,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op         = OP_CAPTURE;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (stat.mode)
                    MODE_INSERT:
                    begin
                        if (stat.full)
                        begin
                            op         = OP_SET_FULL;
                            state_next = S_RESULT;
                        end
                        else if (stat.cnt_zero)
                            state_next = S_PLACE;
                        else
                        begin
                            op         = OP_INS_FIRST;
                            state_next = S_WALK;
                        end
                    end
                    MODE_REMOVE, MODE_SEARCH:
                    begin
                        if (stat.cnt_zero)
                        begin
                            op         = OP_SET_EMPTY;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            op         = OP_HEAD_READ;
                            state_next = (stat.mode == MODE_REMOVE) ? S_REM : S_SRCH;
                        end
                    end
                    default:
                        state_next = S_RESULT;
                endcase
            end
            S_WALK:
            begin
                // walk back from the tail until an entry of equal or higher priority, or the head
                if (stat.ins_stop)
                begin
                    op         = OP_INS_PLACE;
                    state_next = S_RESULT;
                end
                else
                begin
                    op         = OP_INS_SHIFT;
                    state_next = stat.idx_one ? S_PLACE : S_WALK;
                end
            end
            S_PLACE:
            begin
                op         = OP_INS_PLACE;
                state_next = S_RESULT;
            end
            S_REM:
            begin
                op         = OP_REM_POP;
                state_next = S_RESULT;
            end
            S_SRCH:
            begin
                if (stat.hit)
                begin
                    op         = OP_SRCH_HIT;
                    state_next = S_RESULT;
                end
                else if (stat.srch_last)
                    state_next = S_RESULT;
                else
                    op = OP_SRCH_NEXT;
            end
            S_RESULT:
            begin
                // hold until the result register is free
                if (stat.out_free)
                begin
                    op         = OP_COMMIT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign req_ready = (state_reg == S_IDLE);

endmodule

/* hdl/stable_priority_queue.sv */
// Stable priority queue of up to DEPTH tagged entries.
// Usage:
//   Requests arrive on s_tvalid/s_tready; s_tuser carries the mode (insert,
//   remove head, search by tag or no-op), s_tdata the name tag and state code.
//   Each request gives exactly one result on m_tvalid/m_tready with status,
//   found flag, removed entry and the entry count after the operation.
// Timing:
//   One request is worked at a time. A no-op, a refused insert or an
//   empty-queue answer goes straight to the result; a remove reads the
//   head entry and pops it; a search compares entries from the head until a
//   hit or the last entry; an insert moves lower-priority entries one place
//   towards the tail and then places the new entry. The entry memory is
//   walked one entry per cycle. The next request is taken once the result is registered.
// Reset:
//   rst_n clears the count, head pointer and all handshake state; entry
//   storage is not cleared and is only read below the count.
// Stalls:
//   The result register holds while m_tready is low; the next request is
//   still accepted, and its result waits until the register is taken.
// Depends on spq_pkg, spq_ctrl and spq_dp.
module stable_priority_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [spq_pkg::IN_W-1:0]  s_tdata,  // name_tag[63:0], state_code[66:64]
    input  logic [1:0]                s_tuser,  // mode[1:0]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [spq_pkg::OUT_W-1:0] m_tdata   // status[1:0], found[2], removed_tag[66:3],
                                                // removed_state[69:67], entry_count[74:70]
);
    import spq_pkg::*;

    dp_op_t     op;
    dp_status_t stat;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .stat      (stat),
        .op        (op)
    );

    spq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .req_mode  (s_tuser),
        .req_data  (s_tdata),
        .stat      (stat),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (m_tdata)
    );

endmodule

/* bench/tb.sv */
// Self-checking bench for stable_priority_queue: directed corner cases, then random traffic.
// Keeps its own ordered copy of the queue to predict every result.
// Depends on spq_pkg and the stable_priority_queue RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int MAX_WAIT    = 13;
    localparam int RANDOM_REQS = 1527;

    typedef struct {
        logic [TAG_W-1:0]  tag;
        logic [CODE_W-1:0] code;
    } entry_t;

    typedef struct {
        logic [1:0]        status;
        logic              found;
        logic [TAG_W-1:0]  rtag;
        logic [CODE_W-1:0] rcode;
        logic [4:0]        count;
    } outcome_t;

    logic              clk;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic [1:0]        s_tuser  = MODE_NOP;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    entry_t   held_entries[$];
    outcome_t pending_results[$];
    bit       fast_mode;
    int       mismatches, bad_fields, idle_cycles;
    int       n_insert, n_refused, n_remove, n_empty, n_search, n_hit, n_nop, n_checked;

    stable_priority_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int rank_of(input logic [CODE_W-1:0] code);
        case (code)
            3'd1:    return 3;
            3'd2:    return 2;
            3'd3:    return 1;
            default: return 0;
        endcase
    endfunction

    // Apply one request to the held copy and return what the block must answer.
    function automatic outcome_t queue_outcome(input mode_t op, input logic [TAG_W-1:0] tag,
                                               input logic [CODE_W-1:0] code);
        outcome_t res;
        entry_t   e;
        int       pos;
        res = '{status: ST_OK, found: 1'b0, rtag: '0, rcode: '0, count: '0};
        case (op)
            MODE_INSERT:
            begin
                n_insert++;
                if (held_entries.size() >= DEPTH)
                begin
                    res.status = ST_FULL;
                    n_refused++;
                end
                else
                begin
                    pos = 0;
                    while (pos < held_entries.size() &&
                           rank_of(held_entries[pos].code) >= rank_of(code))
                        pos++;
                    e.tag  = tag;
                    e.code = code;
                    held_entries.insert(pos, e);
                end
            end
            MODE_REMOVE:
            begin
                n_remove++;
                if (held_entries.size() == 0)
                begin
                    res.status = ST_EMPTY;
                    n_empty++;
                end
                else
                begin
                    e         = held_entries.pop_front();
                    res.rtag  = e.tag;
                    res.rcode = e.code;
                end
            end
            MODE_SEARCH:
            begin
                n_search++;
                if (held_entries.size() == 0)
                begin
                    res.status = ST_EMPTY;
                    n_empty++;
                end
                else
                begin
                    foreach (held_entries[i])
                        if (held_entries[i].tag == tag)
                            res.found = 1'b1;
                    if (res.found)
                        n_hit++;
                end
            end
            default:
                n_nop++;
        endcase
        res.count = 5'(held_entries.size());
        return res;
    endfunction

    task automatic send_request(input mode_t op, input logic [TAG_W-1:0] tag,
                                input logic [CODE_W-1:0] code);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, MAX_WAIT);
        // keep valid high across back-to-back requests
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_W - TAG_W - CODE_W){1'b0}}, code, tag};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(queue_outcome(op, tag, code));
    endtask

    // Hold off new requests until every outstanding result has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [TAG_W-1:0] random_tag();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic note_mismatch(input string field, input logic [TAG_W-1:0] got,
                                 input logic [TAG_W-1:0] want);
        bad_fields++;
        if (bad_fields <= 10)
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, field, want, got);
    endtask

    // Result side: random stalls, then check each accepted result in order.
    initial
    begin
        outcome_t want;
        int       stall;
        bit       bad;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = fast_mode ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            n_checked++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                bad_fields++;
                if (bad_fields <= 10)
                    $display("%0t: result 0x%0h arrived with nothing outstanding",
                             $realtime, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                bad  = 1'b0;
                if (m_tdata[1:0] !== want.status)
                begin
                    note_mismatch("status", TAG_W'(m_tdata[1:0]), TAG_W'(want.status));
                    bad = 1'b1;
                end
                if (m_tdata[2] !== want.found)
                begin
                    note_mismatch("found", TAG_W'(m_tdata[2]), TAG_W'(want.found));
                    bad = 1'b1;
                end
                if (m_tdata[66:3] !== want.rtag)
                begin
                    note_mismatch("removed_tag", m_tdata[66:3], want.rtag);
                    bad = 1'b1;
                end
                if (m_tdata[69:67] !== want.rcode)
                begin
                    note_mismatch("removed_state", TAG_W'(m_tdata[69:67]), TAG_W'(want.rcode));
                    bad = 1'b1;
                end
                if (m_tdata[74:70] !== want.count)
                begin
                    note_mismatch("entry_count", TAG_W'(m_tdata[74:70]), TAG_W'(want.count));
                    bad = 1'b1;
                end
                if (bad)
                    mismatches++;
            end
        end
    end

    // Watchdog: give up after a long stretch with no handshake on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_empty_queue();
        send_request(MODE_REMOVE, '1, 3'd7);
        send_request(MODE_SEARCH, '0, 3'd0);
        send_request(MODE_NOP, '1, 3'd7);
    endtask

    // Fill with every state code twice so equal priorities must keep arrival order.
    task automatic test_fill_to_full();
        logic [TAG_W-1:0] first_tag, last_tag;
        first_tag = '0;
        last_tag  = '1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
                send_request(MODE_INSERT, first_tag, 3'(i));
            else if (i == DEPTH - 1)
                send_request(MODE_INSERT, last_tag, 3'(i));
            else
                send_request(MODE_INSERT, {$urandom, $urandom}, 3'(i));
        end
        send_request(MODE_INSERT, 64'h5555_aaaa_5555_aaaa, 3'd1);
        send_request(MODE_SEARCH, last_tag, 3'd0);
        send_request(MODE_SEARCH, 64'h0123_4567_89ab_cdef, 3'd0);
        send_request(MODE_NOP, 64'haaaa_5555_aaaa_5555, 3'd3);
    endtask

    task automatic test_random_traffic(input int n_reqs);
        int               sent, target, run_len, roll, size;
        bit               paused;
        mode_t            op;
        logic [TAG_W-1:0] tag;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_reqs)
        begin
            // each run steers the fill level towards a target, extremes often
            roll      = $urandom_range(0, 9);
            target    = (roll < 2) ? 0 : (roll < 4) ? DEPTH : $urandom_range(1, DEPTH - 1);
            run_len   = $urandom_range(8, 40);
            fast_mode = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < run_len && sent < n_reqs; k++)
            begin
                size = held_entries.size();
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    op = MODE_NOP;
                else if (roll < 30)
                    op = MODE_SEARCH;
                else if (size < target)
                    op = MODE_INSERT;
                else if (size > target)
                    op = MODE_REMOVE;
                else
                    op = $urandom_range(0, 1) ? MODE_INSERT : MODE_REMOVE;
                tag = random_tag();
                // reuse held tags for search hits and duplicate inserts
                if (size > 0 && ((op == MODE_SEARCH && $urandom_range(0, 1)) ||
                                 (op == MODE_INSERT && $urandom_range(0, 3) == 0)))
                    tag = held_entries[$urandom_range(0, size - 1)].tag;
                send_request(op, tag, 3'($urandom_range(0, 7)));
                sent++;
            end
            if (!paused && sent >= n_reqs / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
        end
        fast_mode = 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_queue();
        test_fill_to_full();
        drain_results();
        test_random_traffic(RANDOM_REQS);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);
        $display("Covered %0d inserts (%0d refused when full), %0d removes,",
                 n_insert, n_refused, n_remove);
        $display("%0d searches (%0d hits), %0d no-ops and %0d empty-queue answers;",
                 n_search, n_hit, n_nop, n_empty);
        $display("%0d results checked, %0d bad fields", n_checked, bad_fields);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
